@@ hdl/etme_pkg.sv @@
`timescale 1ns / 1ps

package etme_pkg;

    localparam logic [7:0] MARKER_BYTE = 8'hC0;

    localparam logic [1:0] OP_STREAM     = 2'd0;
    localparam logic [1:0] OP_WRITE_BYTE = 2'd1;
    localparam logic [1:0] OP_SET_LEN    = 2'd2;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] data_byte;
        logic       end_of_stream;
        logic [7:0] macro_index;
        logic [3:0] byte_offset;
        logic [4:0] macro_length;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       stream_done;
    } out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_EMIT_MARK,
        S_EMIT_BYTE,
        S_READ,
        S_EXPAND
    } state_t;

    typedef enum logic [1:0] {
        SEL_MARK,
        SEL_HELD,
        SEL_MEM
    } sel_t;

    typedef struct packed {
        logic take;
        logic emit;
        sel_t sel;
        logic emit_last;
        logic emit_eos;
        logic pend_set;
        logic pend_clr;
        logic cnt_clr;
        logic cnt_inc;
        logic rd_byte;
    } cmd_t;

    typedef struct packed {
        logic in_stream;
        logic in_open_marker;
        logic pending;
        logic hit;
        logic held_open_marker;
        logic last_byte;
        logic out_free;
    } sts_t;

endpackage

@@ hdl/etme_ctrl.sv @@
`timescale 1ns / 1ps

module etme_ctrl
    import etme_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  sts_t   sts,
    output logic   in_stall,
    output cmd_t   cmd,
    output state_t state
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        cmd        = '0;
        cmd.sel    = SEL_HELD;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (sts.in_stream)
                    begin
                        if (sts.pending)
                        begin
                            state_next = S_LOOKUP;
                        end
                        else if (sts.in_open_marker)
                        begin
                            cmd.pend_set = 1'b1;
                        end
                        else
                        begin
                            state_next = S_EMIT_BYTE;
                        end
                    end
                end
            end
            S_LOOKUP:
            begin
                cmd.pend_clr = 1'b1;
                if (sts.hit)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_READ;
                end
                else
                begin
                    state_next = S_EMIT_MARK;
                end
            end
            S_EMIT_MARK:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.sel       = SEL_MARK;
                    cmd.emit_last = sts.held_open_marker;
                    // a second marker in the index slot re-arms instead of passing
                    if (sts.held_open_marker)
                    begin
                        cmd.pend_set = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_EMIT_BYTE;
                    end
                end
            end
            S_EMIT_BYTE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.sel       = SEL_HELD;
                    cmd.emit_last = 1'b1;
                    cmd.emit_eos  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_READ:
            begin
                cmd.rd_byte = 1'b1;
                state_next  = S_EXPAND;
            end
            S_EXPAND:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.sel       = SEL_MEM;
                    cmd.emit_last = sts.last_byte;
                    cmd.emit_eos  = 1'b1;
                    if (sts.last_byte)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.cnt_inc = 1'b1;
                        state_next  = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign state = state_reg;

endmodule

@@ hdl/etme_dp.sv @@
`timescale 1ns / 1ps

module etme_dp
    import etme_pkg::*;
#(
    parameter int MAX_MACRO_LEN = 16,
    parameter int NUM_MACROS    = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  in_t        in_data,
    input  logic       out_stall,
    output logic       out_valid,
    output out_t       out_data,
    input  logic       cfg_we,
    input  logic [8:0] cfg_data,
    input  cmd_t       cmd,
    output sts_t       sts
);

    localparam int LW    = $clog2(MAX_MACRO_LEN + 1);
    localparam int CW    = (MAX_MACRO_LEN > 1) ? $clog2(MAX_MACRO_LEN) : 1;
    localparam int IW    = (NUM_MACROS > 1) ? $clog2(NUM_MACROS) : 1;
    localparam int DEPTH = NUM_MACROS * MAX_MACRO_LEN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [LW-1:0]         len_mem [NUM_MACROS];
    logic [7:0]            byte_mem [DEPTH];

    logic [NUM_MACROS-1:0] len_vld_reg, len_vld_next;
    logic [LW-1:0]         len_rd_reg;
    logic                  vld_rd_reg;
    logic [7:0]            byte_rd_reg;
    logic [7:0]            held_byte_reg;
    logic                  held_eos_reg;
    logic                  pend_reg, pend_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [8:0]            count_reg, count_next;
    logic                  out_valid_reg, out_valid_next;
    out_t                  out_data_reg, out_data_next;

    logic                  idx_ok;
    logic                  off_ok;
    logic                  wr_byte;
    logic                  wr_len;
    logic [LW-1:0]         len_sat;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr;
    logic                  out_free;

    assign idx_ok  = {1'b0, in_data.macro_index} < 9'(NUM_MACROS);
    assign off_ok  = 32'(in_data.byte_offset) < MAX_MACRO_LEN;
    assign wr_byte = cmd.take && (in_data.operation == OP_WRITE_BYTE) && idx_ok && off_ok;
    assign wr_len  = cmd.take && (in_data.operation == OP_SET_LEN) && idx_ok;
    assign len_sat = (32'(in_data.macro_length) > MAX_MACRO_LEN) ?
                     LW'(MAX_MACRO_LEN) : LW'(in_data.macro_length);
    assign wr_addr = AW'(in_data.macro_index) * AW'(MAX_MACRO_LEN)
                     + AW'(in_data.byte_offset);
    assign rd_addr = AW'(held_byte_reg) * AW'(MAX_MACRO_LEN) + AW'(cnt_reg);
    assign out_free = !out_valid_reg || !out_stall;

    // length table: written on a length word, read with the candidate index on every take
    always_ff @(posedge clk)
    begin
        if (wr_len)
        begin
            len_mem[in_data.macro_index[IW-1:0]] <= len_sat;
        end
        if (cmd.take)
        begin
            len_rd_reg <= len_mem[in_data.data_byte[IW-1:0]];
            vld_rd_reg <= len_vld_reg[in_data.data_byte[IW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_byte)
        begin
            byte_mem[wr_addr] <= in_data.data_byte;
        end
        if (cmd.rd_byte)
        begin
            byte_rd_reg <= byte_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            held_byte_reg <= in_data.data_byte;
            held_eos_reg  <= in_data.end_of_stream;
        end
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_vld_reg   <= '0;
            pend_reg      <= 1'b0;
            cnt_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_vld_reg   <= len_vld_next;
            pend_reg      <= pend_next;
            cnt_reg       <= cnt_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        len_vld_next = len_vld_reg;
        if (wr_len)
        begin
            len_vld_next[in_data.macro_index[IW-1:0]] = 1'b1;
        end

        pend_next = pend_reg;
        if (cmd.pend_set)
        begin
            pend_next = 1'b1;
        end
        else if (cmd.pend_clr)
        begin
            pend_next = 1'b0;
        end

        cnt_next = cnt_reg;
        if (cmd.cnt_clr)
        begin
            cnt_next = '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + CW'(1);
        end

        count_next = cfg_we ? cfg_data : count_reg;

        out_data_next = out_data_reg;
        if (cmd.emit)
        begin
            case (cmd.sel)
                SEL_MARK: out_data_next.out_byte = MARKER_BYTE;
                SEL_HELD: out_data_next.out_byte = held_byte_reg;
                SEL_MEM:  out_data_next.out_byte = byte_rd_reg;
                default:  out_data_next.out_byte = held_byte_reg;
            endcase
            out_data_next.last_of_run = cmd.emit_last;
            out_data_next.stream_done = cmd.emit_last && cmd.emit_eos && held_eos_reg;
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_comb
    begin
        sts.in_stream        = in_data.operation == OP_STREAM;
        sts.in_open_marker   = (in_data.data_byte == MARKER_BYTE) && !in_data.end_of_stream;
        sts.pending          = pend_reg;
        sts.hit              = ({1'b0, held_byte_reg} < count_reg)
                               && ({1'b0, held_byte_reg} < 9'(NUM_MACROS))
                               && vld_rd_reg && (len_rd_reg != '0);
        sts.held_open_marker = (held_byte_reg == MARKER_BYTE) && !held_eos_reg;
        sts.last_byte        = (LW'(cnt_reg) + LW'(1)) == len_rd_reg;
        sts.out_free         = out_free;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ hdl/escape_token_macro_expander_top.sv @@
`timescale 1ns / 1ps

// Escape-token macro expander.
// Input channel (in_valid / in_stall / in_data) carries one word per item: a stream
// byte, a macro byte write or a macro length write. Output channel (out_valid /
// out_stall / out_data) carries one expanded byte per word, flagged last_of_run on
// the final byte an item causes and stream_done on the final byte of the stream.
// cfg_we / cfg_data loads macro_count; write it only while the block is idle.
// Per item: table writes, unused operations and a first marker byte are handled in
// S_IDLE; a plain byte then passes through S_EMIT_BYTE; the byte after a marker
// gets a length lookup in S_LOOKUP and then S_READ and S_EXPAND per expanded byte,
// or S_EMIT_MARK (and S_EMIT_BYTE) when the index is rejected. Each expanded byte
// costs one read of the single-port macro memory plus a load of the output
// register. One item is in flight at a time; in_stall is high while it works.
// Reset clears the marker state, macro_count and every length entry (all macros
// undefined); macro byte storage is not cleared. While a valid output word sees
// out_stall, it holds and the sequencer waits; input stays stalled until it drains.
module escape_token_macro_expander_top
    import etme_pkg::*;
#(
    parameter int MAX_MACRO_LEN = 16,
    parameter int NUM_MACROS    = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_t        in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_t       out_data,
    input  logic       cfg_we,
    input  logic [8:0] cfg_data
);

    cmd_t   cmd;
    sts_t   sts;
    state_t state;

    etme_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .in_stall (in_stall),
        .cmd      (cmd),
        .state    (state)
    );

    etme_dp #(
        .MAX_MACRO_LEN (MAX_MACRO_LEN),
        .NUM_MACROS    (NUM_MACROS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

    // a marker can never be armed while a macro is being played out
    assert property (@(posedge clk) disable iff (!rst_n)
        (state == S_READ || state == S_EXPAND) |-> !sts.pending)
    else $error("marker pending during expansion");

    // table writes and unused operations produce nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !sts.in_stream) |=> (state == S_IDLE))
    else $error("non-stream word left the idle state");

    // plain byte with no marker armed goes straight to pass-through
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && sts.in_stream && !sts.pending && !sts.in_open_marker)
        |=> (state == S_EMIT_BYTE))
    else $error("plain byte not passed through");

endmodule
